[src/irx_pkg.sv]
// shared types, codes and encoding helpers for the x86-64 instruction encoder
package irx_pkg;

    localparam int CODE_BYTES = 10;

    localparam logic [4:0] FUNC_NOP    = 5'd0;
    localparam logic [4:0] FUNC_RET    = 5'd1;
    localparam logic [4:0] FUNC_JMP    = 5'd2;
    localparam logic [4:0] FUNC_JCC    = 5'd3;
    localparam logic [4:0] FUNC_CALL   = 5'd4;
    localparam logic [4:0] FUNC_MOV    = 5'd5;
    localparam logic [4:0] FUNC_ADD    = 5'd6;
    localparam logic [4:0] FUNC_SUB    = 5'd7;
    localparam logic [4:0] FUNC_AND    = 5'd8;
    localparam logic [4:0] FUNC_OR     = 5'd9;
    localparam logic [4:0] FUNC_XOR    = 5'd10;
    localparam logic [4:0] FUNC_CMP    = 5'd11;
    localparam logic [4:0] FUNC_MUL    = 5'd12;
    localparam logic [4:0] FUNC_LOAD   = 5'd13;
    localparam logic [4:0] FUNC_STORE  = 5'd14;
    localparam logic [4:0] FUNC_VECADD = 5'd15;
    localparam logic [4:0] FUNC_FADD   = 5'd16;

    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_IMM = 2'd1;
    localparam logic [1:0] KIND_MEM = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ROOM  = 2'd1;
    localparam logic [1:0] STATUS_UNSUP = 2'd2;

    localparam logic [4:0] REG_SP = 5'd16;
    localparam logic [4:0] REG_FP = 5'd17;

    typedef struct packed {
        logic [4:0]         func;
        logic [3:0]         cond;
        logic [1:0]         operand_count;
        logic [1:0]         kind_a;
        logic [1:0]         kind_b;
        logic [1:0]         kind_c;
        logic [4:0]         reg_a;
        logic [4:0]         reg_b;
        logic [4:0]         reg_c;
        logic signed [63:0] imm_value;
        logic [63:0]        guest_pc;
        logic [4:0]         buffer_room;
    } in_item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic [3:0] byte_total;
        logic       is_last;
    } out_item_t;

    // encoded instruction handed from the encoder to the byte serializer
    typedef struct packed {
        logic [CODE_BYTES-1:0][7:0] code;
        logic [3:0]                 len;
        logic [1:0]                 status;
    } enc_t;

    function automatic logic [3:0] map_reg(input logic [4:0] r);
        logic [3:0] m;
        if (r == REG_SP)
            m = 4'd4;
        else if (r == REG_FP)
            m = 4'd5;
        else
            m = r[3:0];
        return m;
    endfunction

    function automatic logic fits8(input logic [63:0] v);
        return (&v[63:7]) || !(|v[63:7]);
    endfunction

    function automatic logic [3:0] cond_code(input logic [3:0] c);
        logic [3:0] cc;
        unique case (c)
            4'd0:    cc = 4'h4;
            4'd1:    cc = 4'h5;
            4'd2:    cc = 4'h3;
            4'd3:    cc = 4'h2;
            4'd4:    cc = 4'h8;
            4'd5:    cc = 4'h9;
            4'd6:    cc = 4'h0;
            4'd7:    cc = 4'h1;
            4'd8:    cc = 4'h7;
            4'd9:    cc = 4'h6;
            4'd10:   cc = 4'hD;
            4'd11:   cc = 4'hC;
            4'd12:   cc = 4'hF;
            4'd13:   cc = 4'hE;
            default: cc = 4'h4;
        endcase
        return cc;
    endfunction

    function automatic logic [7:0] alu_opcode(input logic [4:0] f);
        logic [7:0] op;
        unique case (f)
            FUNC_ADD: op = 8'h01;
            FUNC_SUB: op = 8'h29;
            FUNC_AND: op = 8'h21;
            FUNC_OR:  op = 8'h09;
            FUNC_XOR: op = 8'h31;
            default:  op = 8'h39;
        endcase
        return op;
    endfunction

    function automatic logic [2:0] alu_ext(input logic [4:0] f);
        logic [2:0] e;
        unique case (f)
            FUNC_ADD: e = 3'd0;
            FUNC_SUB: e = 3'd5;
            FUNC_AND: e = 3'd4;
            FUNC_OR:  e = 3'd1;
            FUNC_XOR: e = 3'd6;
            default:  e = 3'd7;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] rex_rr(input logic [3:0] rg, input logic [3:0] rm);
        return {5'b01001, rg[3], 1'b0, rm[3]};
    endfunction

    function automatic logic [7:0] modrm_rr(input logic [3:0] rg, input logic [3:0] rm);
        return {2'b11, rg[2:0], rm[2:0]};
    endfunction

endpackage

[src/irx_encode.sv]
// combinational encoder: one instruction to its machine code bytes, length and status
module irx_encode
    import irx_pkg::*;
(
    input  in_item_t item,
    output enc_t     enc
);

    logic [4:0]                 f;
    logic [1:0]                 cnt;
    logic [1:0]                 kl;
    logic [4:0]                 rl;
    logic [3:0]                 dst;
    logic [3:0]                 rbm;
    logic [3:0]                 srcm;
    logic [63:0]                immu;
    logic                       short_imm;
    logic [31:0]                rel;
    logic [CODE_BYTES-1:0][7:0] code;
    logic [3:0]                 len;
    logic                       unsup;
    logic [6:0][7:0]            alu_m;
    logic [3:0]                 alu_len;
    logic                       alu_pre;
    logic [7:0][7:0]            mem_m;
    logic [3:0]                 mem_len;
    logic [3:0]                 mreg;
    logic [3:0]                 mbase;
    logic [3:0]                 vd;
    logic [3:0]                 vs;
    logic                       vrex;

    assign f         = item.func;
    assign cnt       = item.operand_count;
    assign immu      = item.imm_value;
    assign short_imm = fits8(immu);
    assign dst       = map_reg(item.reg_a);
    assign rbm       = map_reg(item.reg_b);
    assign srcm      = map_reg(rl);
    assign vd        = item.reg_a[3:0];
    assign vs        = rl[3:0];
    assign vrex      = vd[3] || vs[3];
    assign rel       = immu[31:0] - item.guest_pc[31:0]
                       - ((f == FUNC_JCC) ? 32'd6 : 32'd5);

    // last operand present
    always_comb
    begin
        unique case (cnt)
            2'd3:
            begin
                kl = item.kind_c;
                rl = item.reg_c;
            end
            2'd2:
            begin
                kl = item.kind_b;
                rl = item.reg_b;
            end
            default:
            begin
                kl = item.kind_a;
                rl = item.reg_a;
            end
        endcase
    end

    // alu body, without the register copy prefix
    always_comb
    begin
        alu_m   = '0;
        alu_pre = (cnt == 2'd3) && (f != FUNC_CMP) && (item.kind_b == KIND_REG)
                  && (rbm != dst);
        if (kl == KIND_REG)
        begin
            alu_m[0] = rex_rr(srcm, dst);
            alu_m[1] = alu_opcode(f);
            alu_m[2] = modrm_rr(srcm, dst);
            alu_len  = 4'd3;
        end
        else
        begin
            alu_m[0] = {7'b0100100, dst[3]};
            alu_m[1] = short_imm ? 8'h83 : 8'h81;
            alu_m[2] = {2'b11, alu_ext(f), dst[2:0]};
            if (short_imm)
            begin
                alu_m[3] = immu[7:0];
                alu_len  = 4'd4;
            end
            else
            begin
                alu_m[6:3] = immu[31:0];
                alu_len    = 4'd7;
            end
        end
    end

    // memory form shared by load and store
    always_comb
    begin
        mem_m    = '0;
        mreg     = (f == FUNC_STORE) ? rbm : dst;
        mbase    = (f == FUNC_STORE) ? dst : rbm;
        mem_m[0] = rex_rr(mreg, mbase);
        mem_m[1] = (f == FUNC_STORE) ? 8'h89 : 8'h8B;
        mem_m[2] = {(short_imm ? 2'b01 : 2'b10), mreg[2:0], mbase[2:0]};
        unique case ({mbase[2:0] == 3'd4, short_imm})
            2'b11:
            begin
                mem_m[3] = 8'h24;
                mem_m[4] = immu[7:0];
                mem_len  = 4'd5;
            end
            2'b10:
            begin
                mem_m[3]   = 8'h24;
                mem_m[7:4] = immu[31:0];
                mem_len    = 4'd8;
            end
            2'b01:
            begin
                mem_m[3] = immu[7:0];
                mem_len  = 4'd4;
            end
            default:
            begin
                mem_m[6:3] = immu[31:0];
                mem_len    = 4'd7;
            end
        endcase
    end

    always_comb
    begin
        code  = '0;
        len   = 4'd0;
        unsup = 1'b0;
        unique case (f)
            FUNC_NOP:
            begin
                code[0] = 8'h90;
                len     = 4'd1;
            end
            FUNC_RET:
            begin
                code[0] = 8'hC3;
                len     = 4'd1;
            end
            FUNC_JMP, FUNC_CALL:
            begin
                if (cnt == 2'd0 || item.kind_a != KIND_IMM)
                    unsup = 1'b1;
                code[0]   = (f == FUNC_JMP) ? 8'hE9 : 8'hE8;
                code[4:1] = rel;
                len       = 4'd5;
            end
            FUNC_JCC:
            begin
                if (cnt == 2'd0 || item.kind_a != KIND_IMM)
                    unsup = 1'b1;
                code[0]   = 8'h0F;
                code[1]   = {4'h8, cond_code(item.cond)};
                code[5:2] = rel;
                len       = 4'd6;
            end
            FUNC_MOV:
            begin
                if (cnt != 2'd2 || item.kind_a != KIND_REG)
                    unsup = 1'b1;
                else if (item.kind_b == KIND_IMM)
                begin
                    code[0]   = {7'b0100100, dst[3]};
                    code[1]   = {5'b10111, dst[2:0]};
                    code[9:2] = immu;
                    len       = 4'd10;
                end
                else if (item.kind_b == KIND_REG)
                begin
                    code[0] = rex_rr(rbm, dst);
                    code[1] = 8'h89;
                    code[2] = modrm_rr(rbm, dst);
                    len     = 4'd3;
                end
                else
                    unsup = 1'b1;
            end
            FUNC_ADD, FUNC_SUB, FUNC_AND, FUNC_OR, FUNC_XOR, FUNC_CMP:
            begin
                if (cnt == 2'd0 || (kl != KIND_REG && kl != KIND_IMM))
                    unsup = 1'b1;
                else if (alu_pre)
                begin
                    code[0]   = rex_rr(rbm, dst);
                    code[1]   = 8'h89;
                    code[2]   = modrm_rr(rbm, dst);
                    code[9:3] = alu_m;
                    len       = alu_len + 4'd3;
                end
                else
                begin
                    code[6:0] = alu_m;
                    len       = alu_len;
                end
            end
            FUNC_MUL:
            begin
                if (cnt < 2'd2 || kl != KIND_REG)
                    unsup = 1'b1;
                code[0] = rex_rr(dst, srcm);
                code[1] = 8'h0F;
                code[2] = 8'hAF;
                code[3] = modrm_rr(dst, srcm);
                len     = 4'd4;
            end
            FUNC_LOAD:
            begin
                if (cnt != 2'd2 || item.kind_b != KIND_MEM)
                    unsup = 1'b1;
                code[7:0] = mem_m;
                len       = mem_len;
            end
            FUNC_STORE:
            begin
                if (cnt != 2'd2 || item.kind_a != KIND_MEM)
                    unsup = 1'b1;
                code[7:0] = mem_m;
                len       = mem_len;
            end
            FUNC_VECADD, FUNC_FADD:
            begin
                if (cnt < 2'd2)
                    unsup = 1'b1;
                unique case ({f == FUNC_FADD, vrex})
                    2'b00:
                    begin
                        code[0] = 8'h0F;
                        code[1] = 8'h58;
                        code[2] = modrm_rr(vd, vs);
                        len     = 4'd3;
                    end
                    2'b01:
                    begin
                        code[0] = {5'b01000, vd[3], 1'b0, vs[3]};
                        code[1] = 8'h0F;
                        code[2] = 8'h58;
                        code[3] = modrm_rr(vd, vs);
                        len     = 4'd4;
                    end
                    2'b10:
                    begin
                        code[0] = 8'hF3;
                        code[1] = 8'h0F;
                        code[2] = 8'h58;
                        code[3] = modrm_rr(vd, vs);
                        len     = 4'd4;
                    end
                    default:
                    begin
                        code[0] = 8'hF3;
                        code[1] = {5'b01000, vd[3], 1'b0, vs[3]};
                        code[2] = 8'h0F;
                        code[3] = 8'h58;
                        code[4] = modrm_rr(vd, vs);
                        len     = 4'd5;
                    end
                endcase
            end
            default:
            begin
                unsup = 1'b1;
            end
        endcase
    end

    // room is checked against the whole length before anything goes out
    always_comb
    begin
        enc.code = code;
        enc.len  = len;
        if (unsup)
            enc.status = STATUS_UNSUP;
        else if (item.buffer_room < {1'b0, len})
            enc.status = STATUS_ROOM;
        else
            enc.status = STATUS_OK;
    end

endmodule

[src/irx_serial.sv]
// result register that sends an encoded instruction out one byte per item
module irx_serial
    import irx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  enc_t      enc,
    input  logic      enc_valid,
    output logic      enc_take,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [3:0]                 left_reg;
    logic [3:0]                 left_next;
    logic [CODE_BYTES-1:0][7:0] bytes_reg;
    logic [CODE_BYTES-1:0][7:0] bytes_next;
    logic [1:0]                 status_reg;
    logic [1:0]                 status_next;
    logic [3:0]                 total_reg;
    logic [3:0]                 total_next;
    logic                       ok;
    logic                       last_now;
    logic                       fire;

    assign ok       = (status_reg == STATUS_OK);
    assign last_now = !ok || (left_reg == 4'd1);
    assign fire     = valid_reg && out_ready;
    assign enc_take = enc_valid && (!valid_reg || (fire && last_now));

    always_comb
    begin
        valid_next  = valid_reg;
        left_next   = left_reg;
        bytes_next  = bytes_reg;
        status_next = status_reg;
        total_next  = total_reg;
        if (enc_take)
        begin
            valid_next  = 1'b1;
            left_next   = enc.len;
            bytes_next  = enc.code;
            status_next = enc.status;
            total_next  = enc.len;
        end
        else if (fire)
        begin
            if (last_now)
                valid_next = 1'b0;
            else
            begin
                left_next  = left_reg - 4'd1;
                bytes_next = {8'h00, bytes_reg[CODE_BYTES-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg  <= bytes_next;
        status_reg <= status_next;
        total_reg  <= total_next;
    end

    assign out_valid           = valid_reg;
    assign out_item.code_byte  = ok ? bytes_reg[0] : 8'h00;
    assign out_item.byte_valid = ok;
    assign out_item.status     = status_reg;
    assign out_item.byte_total = ok ? total_reg : 4'd0;
    assign out_item.is_last    = last_now;

endmodule

[src/ir_to_x86_64_encoder.sv]
// top level: input register, instruction encoder and byte serializer
// an accepted item passes the input register, encoder and result register, which
// holds it while busy; throughput: one result item per cycle while out_ready is
// high; an instruction gives one result item per byte (1 to 10), or a single
// status item on failure; the serializer's single byte per cycle sets this rate
// reset: asynchronous active-low, clears the input and result valid flags
module ir_to_x86_64_encoder
    import irx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic     in_valid_reg;
    logic     in_valid_next;
    in_item_t in_item_reg;
    logic     enc_take;
    enc_t     enc;

    assign in_ready = !in_valid_reg || enc_take;

    always_comb
    begin
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (enc_take)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
    end

    irx_encode u_encode (
        .item (in_item_reg),
        .enc  (enc)
    );

    irx_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc       (enc),
        .enc_valid (in_valid_reg),
        .enc_take  (enc_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
